// ===== src/srca_pkg.sv =====
// Shared types, constants and helpers for the selective receive window block.
package srca_pkg;

    // Sizing of the sequence space and of the receive ring.
    localparam int SEQ_BITS    = 16;
    localparam int WINDOW_MAX  = 64;
    localparam int SLOT_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WIN_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int ACK_BITS    = SEQ_BITS + 1;

    // Configuration register layout.
    localparam int TOTAL_BITS    = 16;
    localparam int WSIZE_BITS    = 7;
    localparam int CFG_DATA_BITS = 16;
    localparam logic CFG_TOTAL_COUNT = 1'b0;
    localparam logic CFG_WINDOW_SIZE = 1'b1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 16'hFFFF;
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd8;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // Configuration as seen by the front and the back.
    typedef struct packed {
        logic [TOTAL_BITS-1:0] total_count;
        logic [WSIZE_BITS-1:0] window_size;
        logic                  restart;
    } t_cfg;

    // One classified segment waiting for the back.
    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
        logic                below_total;
    } t_item;

    // Clamp the programmed window to the range 1 to WINDOW_MAX.
    function automatic logic [WIN_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] ws);
        logic [WIN_BITS-1:0] w;
        if (ws == '0) begin
            w = WIN_BITS'(1);
        end else if (int'(ws) > WINDOW_MAX) begin
            w = WIN_BITS'(WINDOW_MAX);
        end else begin
            w = WIN_BITS'(ws);
        end
        return w;
    endfunction

endpackage

// ===== src/srca_front.sv =====
// Front part: takes segment beats and tags them against the transfer length.
module srca_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srca_pkg::t_cfg                i_cfg,
    input  logic                          i_seq_valid,
    output logic                          o_seq_stall,
    input  logic [srca_pkg::SEQ_BITS-1:0] i_seq_num,
    input  logic                          i_q_full,
    output logic                          o_push,
    output srca_pkg::t_item               o_item
);

    // Count of beats taken since the last restart, used to check the queue handshake.
    logic [srca_pkg::SEQ_BITS-1:0] r_beats;

    // Stall while the queue is full; a beat goes straight into the queue.
    assign o_seq_stall      = i_q_full;
    assign o_push           = i_seq_valid && !i_q_full;
    assign o_item.seq       = i_seq_num;
    assign o_item.below_total = i_seq_num < i_cfg.total_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_beats <= '0;
        end else if (o_push) begin
            r_beats <= r_beats + 1'b1;
        end
    end

    // A beat is never pushed into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("push into full queue");

    // The beat counter moves only on a push or a restart.
    a_beats_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_push && !i_cfg.restart) |=> $stable(r_beats))
        else $error("beat counter moved without a push");

    // A tagged segment is below the total only if the total is nonzero.
    a_tag_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.below_total) |-> (i_cfg.total_count != '0))
        else $error("segment tagged in range with zero total");

endmodule

// ===== src/srca_queue.sv =====
// Short queue that decouples the front from the back.
module srca_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_flush,
    input  logic            i_push,
    input  srca_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output srca_pkg::t_item o_item
);

    srca_pkg::t_item                 r_mem [srca_pkg::QUEUE_DEPTH];
    logic [srca_pkg::QPTR_BITS-1:0]  r_wr_ptr;
    logic [srca_pkg::QPTR_BITS-1:0]  r_rd_ptr;
    logic [srca_pkg::QCNT_BITS-1:0]  r_count;

    assign o_full  = (r_count == srca_pkg::QCNT_BITS'(srca_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/srca_back.sv =====
// Back part: updates the receive ring and expected number and issues the ack.
module srca_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  srca_pkg::t_cfg                        i_cfg,
    input  logic                                  i_q_valid,
    input  srca_pkg::t_item                       i_item,
    output logic                                  o_pop,
    output logic                                  o_ack_valid,
    input  logic                                  i_ack_stall,
    output logic signed [srca_pkg::ACK_BITS-1:0]  o_ack_num,
    output logic                                  o_all_received
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state                              r_state;
    logic [srca_pkg::SEQ_BITS-1:0]       r_exp;
    logic [srca_pkg::SLOT_BITS-1:0]      r_head;
    logic [srca_pkg::WINDOW_MAX-1:0]     r_ring;
    logic                                r_ack_valid;
    logic [srca_pkg::ACK_BITS-1:0]       r_ack_num;
    logic                                r_all_received;

    logic [srca_pkg::WIN_BITS-1:0]       w;
    logic [srca_pkg::SEQ_BITS:0]         seq_dist;
    logic                                exp_below;
    logic                                in_order;
    logic                                ahead;
    logic [srca_pkg::WIN_BITS:0]         slot_sum;
    logic [srca_pkg::WIN_BITS:0]         slot_wrap;
    logic [srca_pkg::SLOT_BITS-1:0]      slot;
    logic [srca_pkg::SLOT_BITS-1:0]      n_head;
    logic                                scan_more;
    logic                                out_free;
    logic                                ack_issue;

    // Classify the segment at the head of the queue against the window.
    always_comb begin
        w         = srca_pkg::eff_window(i_cfg.window_size);
        seq_dist  = {1'b0, i_item.seq} - {1'b0, r_exp};
        exp_below = r_exp < i_cfg.total_count;
        in_order  = exp_below && (i_item.seq == r_exp);
        ahead     = exp_below && i_item.below_total && (i_item.seq > r_exp) &&
                    (seq_dist < (srca_pkg::SEQ_BITS + 1)'(w));
        slot_sum  = (srca_pkg::WIN_BITS + 1)'(r_head) +
                    (srca_pkg::WIN_BITS + 1)'(seq_dist[srca_pkg::WIN_BITS-1:0]);
        slot_wrap = (slot_sum >= (srca_pkg::WIN_BITS + 1)'(w)) ?
                    slot_sum - (srca_pkg::WIN_BITS + 1)'(w) : slot_sum;
        slot      = slot_wrap[srca_pkg::SLOT_BITS-1:0];
    end

    // Next ring slot after the head, wrapping at the window.
    always_comb begin
        if ((srca_pkg::WIN_BITS'(r_head) + 1'b1) == w) begin
            n_head = '0;
        end else begin
            n_head = r_head + 1'b1;
        end
    end

    assign scan_more = (r_exp < i_cfg.total_count) && r_ring[r_head];
    assign out_free  = !r_ack_valid || !i_ack_stall;
    assign ack_issue = !i_cfg.restart && (r_state == S_OUT) && out_free;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid && !i_cfg.restart;

    assign o_ack_valid    = r_ack_valid;
    assign o_ack_num      = signed'(r_ack_num);
    assign o_all_received = r_all_received;

    // Sequencer, ring and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_exp          <= '0;
            r_head         <= '0;
            r_ring         <= '0;
            r_ack_valid    <= 1'b0;
            r_ack_num      <= '0;
            r_all_received <= 1'b0;
        end else begin
            if (ack_issue) begin
                r_ack_valid <= 1'b1;
            end else if (r_ack_valid && !i_ack_stall) begin
                r_ack_valid <= 1'b0;
            end
            if (i_cfg.restart) begin
                r_state <= S_IDLE;
                r_exp   <= '0;
                r_head  <= '0;
                r_ring  <= '0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_q_valid) begin
                            if (in_order) begin
                                r_ring[r_head] <= 1'b0;
                                r_exp          <= r_exp + 1'b1;
                                r_head         <= n_head;
                                r_state        <= S_SCAN;
                            end else begin
                                if (ahead) begin
                                    r_ring[slot] <= 1'b1;
                                end
                                r_state <= S_OUT;
                            end
                        end
                    end
                    S_SCAN: begin
                        if (scan_more) begin
                            r_ring[r_head] <= 1'b0;
                            r_exp          <= r_exp + 1'b1;
                            r_head         <= n_head;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        if (out_free) begin
                            r_ack_num      <= {1'b0, r_exp} - 1'b1;
                            r_all_received <= r_exp >= i_cfg.total_count;
                            r_state        <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // The head slot never holds a mark between items.
    a_head_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_ring[r_head])
        else $error("mark left at the expected slot");

    // The head stays inside the effective window.
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (srca_pkg::WIN_BITS'(r_head) < w))
        else $error("ring head outside the window");

    // Expected number never passes the transfer length.
    a_exp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp <= i_cfg.total_count))
        else $error("expected number beyond total");

    // A new ack beat only comes from the output step.
    a_ack_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ack_valid) |-> $past(r_state == S_OUT))
        else $error("ack issued outside the output step");

endmodule

// ===== src/selective_receive_cumulative_ack_top.sv =====
// Top level of the selective repeat receive window with cumulative ack.
//
// Input channel: one beat per arriving segment on i_seq_valid / o_seq_stall
// carrying i_seq_num. Output channel: one ack beat per segment on
// o_ack_valid / i_ack_stall carrying o_ack_num (expected - 1, -1 when
// nothing is in order yet) and o_all_received.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 = total count, 1 = window size); either write restarts the transfer.
// Write only while no segment is in flight.
// A segment goes into a two-entry queue in the cycle it is taken. The back
// then pops and classifies it in its idle step and goes to its output step
// for an out-of-order, duplicate or out-of-range segment, or through its scan
// step first for an in-order one, releasing buffered segments one ring slot
// per cycle. The ack beat is registered in the output step.
// While the ack receiver stalls, the ack beat holds and the back waits in
// its output step; up to two more segments are still taken into the queue.
// Reset (synchronous, active low) sets total count 65535, window 8,
// expected number 0 and clears the ring and the queue at once.
module selective_receive_cumulative_ack_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [srca_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 i_seq_valid,
    output logic                                 o_seq_stall,
    input  logic [srca_pkg::SEQ_BITS-1:0]        i_seq_num,
    output logic                                 o_ack_valid,
    input  logic                                 i_ack_stall,
    output logic signed [srca_pkg::ACK_BITS-1:0] o_ack_num,
    output logic                                 o_all_received
);

    logic [srca_pkg::TOTAL_BITS-1:0] r_total_count;
    logic [srca_pkg::WSIZE_BITS-1:0] r_window_size;
    srca_pkg::t_cfg                  cfg;
    logic                            q_full;
    logic                            q_push;
    logic                            q_pop;
    logic                            q_valid;
    srca_pkg::t_item                 push_item;
    srca_pkg::t_item                 head_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_count <= srca_pkg::TOTAL_RESET;
            r_window_size <= srca_pkg::WSIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                srca_pkg::CFG_TOTAL_COUNT:
                    r_total_count <= i_cfg_data[srca_pkg::TOTAL_BITS-1:0];
                srca_pkg::CFG_WINDOW_SIZE:
                    r_window_size <= i_cfg_data[srca_pkg::WSIZE_BITS-1:0];
                default: begin
                    r_total_count <= r_total_count;
                end
            endcase
        end
    end

    assign cfg.total_count = r_total_count;
    assign cfg.window_size = r_window_size;
    assign cfg.restart     = i_cfg_we;

    srca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_seq_valid (i_seq_valid),
        .o_seq_stall (o_seq_stall),
        .i_seq_num   (i_seq_num),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_item      (push_item)
    );

    srca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (cfg.restart),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    srca_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_valid      (q_valid),
        .i_item         (head_item),
        .o_pop          (q_pop),
        .o_ack_valid    (o_ack_valid),
        .i_ack_stall    (i_ack_stall),
        .o_ack_num      (o_ack_num),
        .o_all_received (o_all_received)
    );

endmodule

// ===== verif/selective_receive_cumulative_ack_top_tb.sv =====
// Self-checking testbench for the selective repeat receive window with cumulative ack.
module selective_receive_cumulative_ack_top_tb;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 11;
    // Drain margin after the last expected ack is seen.
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam logic [srca_pkg::ACK_BITS-1:0] ACK_NONE = '1;
    localparam int N_DIR = 28;
    localparam int N_PHASES = 7;

    typedef enum logic {ROW_SEQ, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} t_rx_mode;

    // One ack beat as the block should send it.
    typedef struct packed {
        logic [srca_pkg::ACK_BITS-1:0] ack;
        logic                          all_rcvd;
    } t_ack_beat;

    // One directed step: a register write or a segment, with an optional typed answer.
    typedef struct packed {
        t_row_kind                     kind;
        logic                          reg_idx;
        logic [15:0]                   data;
        logic                          typed;
        logic [srca_pkg::ACK_BITS-1:0] ack;
        logic                          all_rcvd;
    } t_dir_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic                                 i_cfg_index = srca_pkg::CFG_TOTAL_COUNT;
    logic [srca_pkg::CFG_DATA_BITS-1:0]   i_cfg_data = '0;
    logic                                 i_seq_valid = 1'b0;
    logic                                 o_seq_stall;
    logic [srca_pkg::SEQ_BITS-1:0]        i_seq_num = '0;
    logic                                 o_ack_valid;
    logic                                 i_ack_stall = 1'b0;
    logic signed [srca_pkg::ACK_BITS-1:0] o_ack_num;
    logic                                 o_all_received;

    // Window state as the block should hold it.
    int          win_total = 65535;
    logic [6:0]  win_size = 7'd8;
    int          win_expected = 0;
    bit          win_marks [srca_pkg::WINDOW_MAX];

    t_ack_beat   pending_acks [$];
    int          n_errors = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    t_dir_row    dir_tab [N_DIR];
    int          phase_total [N_PHASES] = '{40, 300, 1, 150, 65535, 90, 120};
    int          phase_win [N_PHASES] = '{4, 64, 1, 127, 16, 0, 9};
    int          phase_len [N_PHASES] = '{80, 120, 20, 100, 100, 60, 140};

    selective_receive_cumulative_ack_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_seq_valid    (i_seq_valid),
        .o_seq_stall    (o_seq_stall),
        .i_seq_num      (i_seq_num),
        .o_ack_valid    (o_ack_valid),
        .i_ack_stall    (i_ack_stall),
        .o_ack_num      (o_ack_num),
        .o_all_received (o_all_received)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Programmed window clamped to 1..WINDOW_MAX.
    function automatic int live_window();
        if (win_size == 7'd0) return 1;
        if (int'(win_size) > srca_pkg::WINDOW_MAX) return srca_pkg::WINDOW_MAX;
        return int'(win_size);
    endfunction

    // Apply one arriving segment to the window and return the ack it earns.
    function automatic t_ack_beat take_segment(input logic [15:0] seq);
        int w;
        int e;
        int s;
        int start;
        t_ack_beat beat;
        w = live_window();
        e = win_expected;
        s = int'(seq);
        if (e < win_total) begin
            if (s == e) begin
                start = e;
                win_marks[e % w] = 1'b0;
                e++;
                // Slide past every segment already buffered right behind it.
                while (e < win_total && e < start + w && win_marks[e % w]) begin
                    win_marks[e % w] = 1'b0;
                    e++;
                end
                win_expected = e;
            end else if (s > e && s < e + w && s < win_total) begin
                win_marks[s % w] = 1'b1;
            end
        end
        beat.ack = srca_pkg::ACK_BITS'(win_expected - 1);
        beat.all_rcvd = (win_expected >= win_total);
        return beat;
    endfunction

    // Mostly in-window traffic around the expected number, plus edges and noise.
    function automatic logic [15:0] pick_seq();
        int w;
        int e;
        int r;
        w = live_window();
        e = win_expected;
        r = $urandom_range(0, 99);
        if (r < 25) return 16'(e);
        if (r < 65) return 16'(e + $urandom_range(0, w - 1));
        if (r < 75) return 16'(e + w + $urandom_range(0, 3));
        if (r < 85) return 16'(e - 1 - $urandom_range(0, w - 1));
        if (r < 92) return 16'(win_total - 2 + $urandom_range(0, 4));
        return 16'($urandom());
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // Wait until the block is idle, then write one register and restart the window.
    task automatic write_reg(input logic idx, input logic [15:0] data);
        i_seq_valid <= 1'b0;
        while (pending_acks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == srca_pkg::CFG_TOTAL_COUNT) begin
            win_total = int'(data);
        end else begin
            win_size = data[6:0];
        end
        win_expected = 0;
        foreach (win_marks[i]) win_marks[i] = 1'b0;
    endtask

    // Offer one segment beat, record its ack once taken, then maybe pause.
    task automatic offer_segment(input logic [15:0] seq, input logic typed,
                                 input t_ack_beat typed_beat);
        t_ack_beat beat;
        int gap;
        i_seq_valid <= 1'b1;
        i_seq_num <= seq;
        @(posedge i_clk);
        while (o_seq_stall) @(posedge i_clk);
        beat = take_segment(seq);
        pending_acks.push_back(typed ? typed_beat : beat);
        // Bursts of random length, sometimes long, with random gaps between.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
            i_seq_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver stall pattern, with one long hold-off counted here.
    t_rx_mode rx_mode = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_tick = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left > 0) begin
            i_ack_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_ack_stall <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(20, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_FREE: begin
                    i_ack_stall <= 1'b0;
                end
                RX_LIGHT: begin
                    i_ack_stall <= ($urandom_range(0, 99) < 30);
                end
                RX_PERIODIC: begin
                    i_ack_stall <= (rx_tick % 3 != 0);
                end
                default: begin
                    i_ack_stall <= ($urandom_range(0, 99) < 80);
                end
            endcase
        end
    end

    // Compare every ack beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_ack_beat want;
        if (i_rst_n && o_ack_valid && !i_ack_stall) begin
            if (pending_acks.size() == 0) begin
                report_mismatch($sformatf("ack beat %0d with nothing expected", o_ack_num));
            end else begin
                want = pending_acks.pop_front();
                if (o_ack_num !== want.ack) begin
                    report_mismatch($sformatf("ack_num got %0d want %0d",
                                              o_ack_num, $signed(want.ack)));
                end
                if (o_all_received !== want.all_rcvd) begin
                    report_mismatch($sformatf("all_received got %b want %b",
                                              o_all_received, want.all_rcvd));
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_seq_valid && !o_seq_stall) || (o_ack_valid && !i_ack_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed table, then random phases over several window settings.
    initial begin
        t_dir_row row;
        t_ack_beat typed_beat;
        logic [15:0] wdata;
        // Segment rows leave the register index unused.
        dir_tab = '{
            // After reset: first in-order segment, then the top of the sequence space.
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd0,     1'b1, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'hFFFF,  1'b1, 17'd0,    1'b0},
            // Out of order, then the gap filled releasing buffered segments.
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd3,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd2,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd1,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd1,     1'b0, 17'd0,    1'b0},
            // Just past and just inside the window edge.
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd12,    1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd11,    1'b0, 17'd0,    1'b0},
            // Zero window acts as one.
            '{ROW_CFG, srca_pkg::CFG_WINDOW_SIZE, 16'd0,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd1,     1'b1, ACK_NONE, 1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd0,     1'b1, 17'd0,    1'b0},
            // Zero total: done at once, everything ignored.
            '{ROW_CFG, srca_pkg::CFG_TOTAL_COUNT, 16'd0,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd0,     1'b1, ACK_NONE, 1'b1},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'hFFFF,  1'b1, ACK_NONE, 1'b1},
            // Tiny transfer with an oversized window, completed, then more segments.
            '{ROW_CFG, srca_pkg::CFG_TOTAL_COUNT, 16'd3,     1'b0, 17'd0,    1'b0},
            '{ROW_CFG, srca_pkg::CFG_WINDOW_SIZE, 16'h007F,  1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd2,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd1,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd0,     1'b1, 17'd2,    1'b1},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd3,     1'b1, 17'd2,    1'b1},
            // Largest window, both edges of it.
            '{ROW_CFG, srca_pkg::CFG_TOTAL_COUNT, 16'hFFFF,  1'b0, 17'd0,    1'b0},
            '{ROW_CFG, srca_pkg::CFG_WINDOW_SIZE, 16'd64,    1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd63,    1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd64,    1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'd0,     1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'h8000,  1'b0, 17'd0,    1'b0},
            '{ROW_SEQ, srca_pkg::CFG_TOTAL_COUNT, 16'hFFFE,  1'b0, 17'd0,    1'b0},
            // Upper data bits of a window write are dropped.
            '{ROW_CFG, srca_pkg::CFG_WINDOW_SIZE, 16'hFF88,  1'b0, 17'd0,    1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.reg_idx, row.data);
            end else begin
                typed_beat.ack = row.ack;
                typed_beat.all_rcvd = row.all_rcvd;
                offer_segment(row.data, row.typed, typed_beat);
            end
        end

        typed_beat = '0;
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(srca_pkg::CFG_TOTAL_COUNT, 16'(phase_total[p]));
            wdata = 16'(($urandom_range(0, 511) << 7) | phase_win[p]);
            write_reg(srca_pkg::CFG_WINDOW_SIZE, wdata);
            for (int n = 0; n < phase_len[p]; n++) begin
                // Once, mid-phase, the receiver holds off while segments keep coming.
                if (p == 1 && n == 30) hold_req = 1'b1;
                offer_segment(pick_seq(), 1'b0, typed_beat);
            end
        end

        i_seq_valid <= 1'b0;
        while (pending_acks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
